// ----- rtl/core/jval_pkg.sv -----
// Shared types, widths and helpers for the joint velocity and acceleration limiter.
`timescale 1ns / 1ps
package jval_pkg;

  localparam int MAX_SUBSTEPS = 16;
  localparam int US_PER_S     = 1000000;

  localparam int POS_W   = 24;
  localparam int VLIM_W  = 23;
  localparam int BLEND_W = 17;
  localparam int PER_W   = 20;
  localparam int EL_W    = 22;
  localparam int DT_W    = 22;
  localparam int FRAC_W  = 16;

  localparam int N_W     = $clog2(MAX_SUBSTEPS + 1);
  localparam int DEN_W   = $clog2(MAX_SUBSTEPS * US_PER_S + 1);
  localparam int REM_W   = DT_W + 2;
  localparam int WIDE_W  = 28;
  localparam int BPROD_W = BLEND_W + 1 + POS_W + 1;
  localparam int APROD_W = VLIM_W + DT_W;
  localparam int PROD_W  = POS_W + DT_W + 1;
  localparam int DVD_W   = 46;
  localparam int Q_W     = 26;
  localparam int DCNT_W  = $clog2(DVD_W + 1);

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_POS_LOW   = 3'd0;
  localparam logic [IDX_W-1:0] REG_POS_HIGH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_VEL_LIMIT = 3'd2;
  localparam logic [IDX_W-1:0] REG_ACC_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_BLEND     = 3'd4;
  localparam logic [IDX_W-1:0] REG_CTRL_PER  = 3'd5;
  localparam logic [IDX_W-1:0] REG_OUT_PER   = 3'd6;

  typedef struct packed {
    logic [POS_W-1:0]   pos_low;
    logic [POS_W-1:0]   pos_high;
    logic [VLIM_W-1:0]  vel_limit;
    logic [VLIM_W-1:0]  acc_limit;
    logic [BLEND_W-1:0] blend;
    logic [PER_W-1:0]   ctrl_period;
    logic [PER_W-1:0]   out_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pos_low:     24'h800000,
    pos_high:    24'h7fffff,
    vel_limit:   23'd65536,
    acc_limit:   23'd131072,
    blend:       17'd1311,
    ctrl_period: 20'd10000,
    out_period:  20'd5000
  };

  typedef struct packed {
    logic load;
    logic bmul;
    logic badd;
    logic cnt_step;
    logic den;
    logic div_go;
    logic da_load;
    logic vel;
    logic vmul;
    logic pos;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_done;
    logic div_done;
    logic last;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [WIDE_W-1:0] ext_pos(input logic [POS_W-1:0] x);
    ext_pos = {{(WIDE_W-POS_W){x[POS_W-1]}}, x};
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] lo;
    logic signed [WIDE_W-1:0] hi;
    lo = {{(WIDE_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};
    hi = {{(WIDE_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    if (x < lo) begin
      sat_pos = lo[POS_W-1:0];
    end else if (x > hi) begin
      sat_pos = hi[POS_W-1:0];
    end else begin
      sat_pos = x[POS_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/jval_if.sv -----
// Valid/ready channel interfaces for the tick input and the position output.
`timescale 1ns / 1ps
interface jval_in_if;
  logic                         valid;
  logic                         ready;
  logic [jval_pkg::POS_W-1:0]   vel_request;
  logic [jval_pkg::POS_W-1:0]   feedback_position;
  logic [jval_pkg::EL_W-1:0]    elapsed_us;

  modport source (output valid, vel_request, feedback_position, elapsed_us,
                  input ready);
  modport sink (input valid, vel_request, feedback_position, elapsed_us,
                output ready);
endinterface

interface jval_out_if;
  logic                       valid;
  logic                       ready;
  logic [jval_pkg::POS_W-1:0] command_position;
  logic                       last_point;

  modport source (output valid, command_position, last_point, input ready);
  modport sink (input valid, command_position, last_point, output ready);
endinterface

// ----- rtl/core/jval_regs.sv -----
// APB configuration register file.
`timescale 1ns / 1ps
module jval_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jval_pkg::ADDR_W-1:0]  paddr,
  input  logic [jval_pkg::DATA_W-1:0]  pwdata,
  output logic [jval_pkg::DATA_W-1:0]  prdata,
  output jval_pkg::cfg_t               cfg
);

  jval_pkg::cfg_t                   cfg_r;
  logic [jval_pkg::IDX_W-1:0]       idx;
  logic                             wr;

  assign idx = paddr[jval_pkg::ADDR_W-1:2];
  assign wr  = psel & penable & pwrite;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= jval_pkg::CFG_RESET;
    end else if (wr) begin
      unique case (idx)
        jval_pkg::REG_POS_LOW:   cfg_r.pos_low     <= pwdata[jval_pkg::POS_W-1:0];
        jval_pkg::REG_POS_HIGH:  cfg_r.pos_high    <= pwdata[jval_pkg::POS_W-1:0];
        jval_pkg::REG_VEL_LIMIT: cfg_r.vel_limit   <= pwdata[jval_pkg::VLIM_W-1:0];
        jval_pkg::REG_ACC_LIMIT: cfg_r.acc_limit   <= pwdata[jval_pkg::VLIM_W-1:0];
        jval_pkg::REG_BLEND:     cfg_r.blend       <= pwdata[jval_pkg::BLEND_W-1:0];
        jval_pkg::REG_CTRL_PER:  cfg_r.ctrl_period <= pwdata[jval_pkg::PER_W-1:0];
        jval_pkg::REG_OUT_PER:   cfg_r.out_period  <= pwdata[jval_pkg::PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      jval_pkg::REG_POS_LOW:   prdata = jval_pkg::DATA_W'(cfg_r.pos_low);
      jval_pkg::REG_POS_HIGH:  prdata = jval_pkg::DATA_W'(cfg_r.pos_high);
      jval_pkg::REG_VEL_LIMIT: prdata = jval_pkg::DATA_W'(cfg_r.vel_limit);
      jval_pkg::REG_ACC_LIMIT: prdata = jval_pkg::DATA_W'(cfg_r.acc_limit);
      jval_pkg::REG_BLEND:     prdata = jval_pkg::DATA_W'(cfg_r.blend);
      jval_pkg::REG_CTRL_PER:  prdata = jval_pkg::DATA_W'(cfg_r.ctrl_period);
      jval_pkg::REG_OUT_PER:   prdata = jval_pkg::DATA_W'(cfg_r.out_period);
      default:                 prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/jval_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module jval_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [jval_pkg::DVD_W-1:0]  dividend,
  input  logic [jval_pkg::DEN_W-1:0]  divisor,
  output logic [jval_pkg::Q_W-1:0]    quo,
  output logic                        done
);

  logic [jval_pkg::DEN_W-1:0]   rem_r;
  logic [jval_pkg::DVD_W-1:0]   sh_r;
  logic [jval_pkg::DCNT_W-1:0]  cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [jval_pkg::DEN_W:0]     trial;
  logic [jval_pkg::DEN_W:0]     diff;
  logic                         fits;

  assign trial = {rem_r, sh_r[jval_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};
  assign quo   = sh_r[jval_pkg::Q_W-1:0];
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= jval_pkg::DCNT_W'(jval_pkg::DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - jval_pkg::DCNT_W'(1);
        if (cnt_r == jval_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      sh_r  <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[jval_pkg::DEN_W-1:0] : trial[jval_pkg::DEN_W-1:0];
      sh_r  <= {sh_r[jval_pkg::DVD_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/core/jval_ctrl.sv -----
// Sequencer for tick set-up and the substep loop.
`timescale 1ns / 1ps
module jval_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jval_pkg::dp_sts_t   sts,
  output jval_pkg::dp_cmd_t   cmd
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_BMUL    = 12'b0000_0000_0010,
    S_BADD    = 12'b0000_0000_0100,
    S_COUNT   = 12'b0000_0000_1000,
    S_DEN     = 12'b0000_0001_0000,
    S_DA_GO   = 12'b0000_0010_0000,
    S_DA_WAIT = 12'b0000_0100_0000,
    S_VEL     = 12'b0000_1000_0000,
    S_VMUL    = 12'b0001_0000_0000,
    S_P_GO    = 12'b0010_0000_0000,
    S_P_WAIT  = 12'b0100_0000_0000,
    S_POS     = 12'b1000_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_BMUL;
        end
      end
      S_BMUL: begin
        cmd.bmul  = 1'b1;
        state_nxt = S_BADD;
      end
      S_BADD: begin
        cmd.badd  = 1'b1;
        state_nxt = S_COUNT;
      end
      S_COUNT: begin
        if (sts.cnt_done) begin
          state_nxt = S_DEN;
        end else begin
          cmd.cnt_step = 1'b1;
        end
      end
      S_DEN: begin
        cmd.den   = 1'b1;
        state_nxt = S_DA_GO;
      end
      S_DA_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DA_WAIT;
      end
      S_DA_WAIT: begin
        if (sts.div_done) begin
          cmd.da_load = 1'b1;
          state_nxt   = S_VEL;
        end
      end
      S_VEL: begin
        cmd.vel   = 1'b1;
        state_nxt = S_VMUL;
      end
      S_VMUL: begin
        cmd.vmul  = 1'b1;
        state_nxt = S_P_GO;
      end
      S_P_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_P_WAIT;
      end
      S_P_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        if (sts.out_free) begin
          cmd.pos   = 1'b1;
          state_nxt = sts.last ? S_IDLE : S_VEL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/jval_dpath.sv -----
// Datapath: joint state, blend, substep count, limits and the output word register.
`timescale 1ns / 1ps
module jval_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  jval_pkg::cfg_t              cfg,
  input  jval_pkg::dp_cmd_t           cmd,
  output jval_pkg::dp_sts_t           sts,
  input  logic [jval_pkg::POS_W-1:0]  in_req,
  input  logic [jval_pkg::POS_W-1:0]  in_fb,
  input  logic [jval_pkg::EL_W-1:0]   in_el,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [jval_pkg::POS_W-1:0]  out_pos,
  output logic                        out_last
);

  localparam int WW = jval_pkg::WIDE_W;

  logic [jval_pkg::POS_W-1:0]   req_r;
  logic [jval_pkg::POS_W-1:0]   fb_r;
  logic [jval_pkg::EL_W-1:0]    el_r;
  logic [jval_pkg::POS_W-1:0]   pos_r;
  logic [jval_pkg::POS_W-1:0]   vel_r;
  logic                         primed_r;
  logic [jval_pkg::PROD_W-1:0]  prod_r;
  logic [jval_pkg::DT_W-1:0]    dt_r;
  logic [jval_pkg::REM_W-1:0]   rem_r;
  logic [jval_pkg::N_W-1:0]     cnt_r;
  logic [jval_pkg::N_W-1:0]     n_r;
  logic [jval_pkg::N_W-1:0]     k_r;
  logic [jval_pkg::DEN_W-1:0]   den_r;
  logic [jval_pkg::Q_W-1:0]     da_r;
  logic                         neg_r;
  logic [jval_pkg::POS_W-1:0]   opos_r;
  logic                         olast_r;
  logic                         ovalid_r;
  logic                         ovalid_nxt;

  // blend
  logic signed [WW-1:0]                  diff;
  logic signed [jval_pkg::BPROD_W-1:0]   bprod;
  logic                                  prod_neg;
  logic [jval_pkg::PROD_W-1:0]           prod_mag;
  logic [jval_pkg::PROD_W-1:0]           brnd;
  logic signed [WW-1:0]                  bstep_mag;
  logic signed [WW-1:0]                  bsum;

  // time and substep count
  logic [jval_pkg::DT_W-1:0]    dt_lo;
  logic [jval_pkg::DT_W-1:0]    dt_hi;
  logic [jval_pkg::DT_W-1:0]    dt_a;
  logic [jval_pkg::DT_W-1:0]    dt_c;
  logic [jval_pkg::REM_W-1:0]   two_oper;
  logic [jval_pkg::REM_W-1:0]   rem_init;
  logic                         cnt_go;
  logic [jval_pkg::N_W-1:0]     n_c;

  // products and divider
  logic [jval_pkg::APROD_W-1:0]        aprod;
  logic signed [jval_pkg::PROD_W-1:0]  vprod;
  logic [jval_pkg::DVD_W-1:0]          dividend;
  logic [jval_pkg::Q_W-1:0]            quo;
  logic                                div_done;

  // velocity
  logic signed [WW-1:0]  vl;
  logic signed [WW-1:0]  req_w;
  logic signed [WW-1:0]  w_a;
  logic signed [WW-1:0]  w_c;
  logic signed [WW-1:0]  da_w;
  logic signed [WW-1:0]  v_w;
  logic signed [WW-1:0]  vlo;
  logic signed [WW-1:0]  vhi;
  logic signed [WW-1:0]  nv_a;
  logic signed [WW-1:0]  nv_c;

  // position
  logic signed [WW-1:0]  qmag;
  logic signed [WW-1:0]  psum;
  logic signed [WW-1:0]  low_w;
  logic signed [WW-1:0]  high_w;
  logic signed [WW-1:0]  p_a;
  logic signed [WW-1:0]  p_c;
  logic                  at_lim;

  assign diff  = jval_pkg::ext_pos(fb_r) - jval_pkg::ext_pos(pos_r);
  assign bprod = $signed({1'b0, cfg.blend}) * $signed(diff[jval_pkg::POS_W:0]);

  assign prod_neg  = prod_r[jval_pkg::PROD_W-1];
  assign prod_mag  = prod_neg ? (~prod_r + jval_pkg::PROD_W'(1)) : prod_r;
  assign brnd      = (prod_mag + jval_pkg::PROD_W'(1 << (jval_pkg::FRAC_W - 1)))
                     >> jval_pkg::FRAC_W;
  assign bstep_mag = {1'b0, brnd[WW-2:0]};
  assign bsum      = jval_pkg::ext_pos(pos_r) + (prod_neg ? -bstep_mag : bstep_mag);

  assign dt_lo    = jval_pkg::DT_W'(cfg.ctrl_period >> 1);
  assign dt_hi    = jval_pkg::DT_W'({cfg.ctrl_period, 1'b0});
  assign dt_a     = (el_r < dt_lo) ? dt_lo : el_r;
  assign dt_c     = (dt_a > dt_hi) ? dt_hi : dt_a;
  assign two_oper = jval_pkg::REM_W'({cfg.out_period, 1'b0});
  assign rem_init = jval_pkg::REM_W'({dt_c, 1'b0}) + jval_pkg::REM_W'(cfg.out_period);
  assign cnt_go   = (rem_r >= two_oper) && (cnt_r < jval_pkg::N_W'(jval_pkg::MAX_SUBSTEPS));
  assign n_c      = (cnt_r == '0) ? jval_pkg::N_W'(1) : cnt_r;

  assign aprod    = cfg.acc_limit * dt_r;
  assign vprod    = $signed(vel_r) * $signed({1'b0, dt_r});
  assign dividend = prod_mag[jval_pkg::DVD_W-1:0] + jval_pkg::DVD_W'(den_r >> 1);

  assign vl    = {{(WW-jval_pkg::VLIM_W){1'b0}}, cfg.vel_limit};
  assign req_w = jval_pkg::ext_pos(req_r);
  assign w_a   = (req_w < -vl) ? -vl : req_w;
  assign w_c   = (w_a > vl) ? vl : w_a;
  assign da_w  = {{(WW-jval_pkg::Q_W){1'b0}}, da_r};
  assign v_w   = jval_pkg::ext_pos(vel_r);
  assign vlo   = v_w - da_w;
  assign vhi   = v_w + da_w;
  assign nv_a  = (w_c < vlo) ? vlo : w_c;
  assign nv_c  = (nv_a > vhi) ? vhi : nv_a;

  assign qmag   = {{(WW-jval_pkg::Q_W){1'b0}}, quo};
  assign psum   = jval_pkg::ext_pos(pos_r) + (neg_r ? -qmag : qmag);
  assign low_w  = jval_pkg::ext_pos(cfg.pos_low);
  assign high_w = jval_pkg::ext_pos(cfg.pos_high);
  assign p_a    = (psum < low_w) ? low_w : psum;
  assign p_c    = (p_a > high_w) ? high_w : p_a;
  assign at_lim = (p_c == low_w) || (p_c == high_w);

  jval_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (dividend),
    .divisor  (den_r),
    .quo      (quo),
    .done     (div_done)
  );

  assign sts.cnt_done = !cnt_go;
  assign sts.div_done = div_done;
  assign sts.last     = (k_r == (n_r - jval_pkg::N_W'(1)));
  assign sts.out_free = !ovalid_r || out_ready;

  assign out_valid = ovalid_r;
  assign out_pos   = opos_r;
  assign out_last  = olast_r;

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.pos) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      pos_r    <= '0;
      vel_r    <= '0;
      cnt_r    <= '0;
      k_r      <= '0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (cmd.load && !primed_r) begin
        primed_r <= 1'b1;
        pos_r    <= in_fb;
        vel_r    <= '0;
      end
      if (cmd.badd) begin
        pos_r <= jval_pkg::sat_pos(bsum);
        cnt_r <= '0;
      end
      if (cmd.cnt_step && cnt_go) begin
        cnt_r <= cnt_r + jval_pkg::N_W'(1);
      end
      if (cmd.den) begin
        k_r <= '0;
      end
      if (cmd.vel) begin
        vel_r <= jval_pkg::sat_pos(nv_c);
      end
      if (cmd.pos) begin
        pos_r <= p_c[jval_pkg::POS_W-1:0];
        k_r   <= k_r + jval_pkg::N_W'(1);
        if (at_lim) begin
          vel_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
      fb_r  <= in_fb;
      el_r  <= in_el;
    end
    if (cmd.bmul) begin
      prod_r <= {{(jval_pkg::PROD_W-jval_pkg::BPROD_W){bprod[jval_pkg::BPROD_W-1]}}, bprod};
    end
    if (cmd.badd) begin
      dt_r  <= dt_c;
      rem_r <= rem_init;
    end
    if (cmd.cnt_step && cnt_go) begin
      rem_r <= rem_r - two_oper;
    end
    if (cmd.den) begin
      n_r    <= n_c;
      den_r  <= jval_pkg::DEN_W'(n_c) * jval_pkg::DEN_W'(jval_pkg::US_PER_S);
      prod_r <= {{(jval_pkg::PROD_W-jval_pkg::APROD_W){1'b0}}, aprod};
    end
    if (cmd.vmul) begin
      prod_r <= vprod;
    end
    if (cmd.div_go) begin
      neg_r <= prod_neg;
    end
    if (cmd.da_load) begin
      da_r <= quo;
    end
    if (cmd.pos) begin
      opos_r  <= p_c[jval_pkg::POS_W-1:0];
      olast_r <= sts.last;
    end
  end

endmodule

// ----- rtl/core/joint_velocity_accel_limiter.sv -----
// Top level: one-joint velocity and acceleration limited position integrator.
// A tick yields n = 1..16 substeps and one output word per substep; the divider is
// shared between the acceleration step of each tick and the position step of each substep.
// The next tick is taken once the last word sits in the output register.
// Reset (rst_n low, synchronous) restores register defaults and unprimed joint state.
`timescale 1ns / 1ps
module joint_velocity_accel_limiter (
  input  logic                         clk,
  input  logic                         rst_n,
  jval_in_if.sink                      in_ch,
  jval_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [jval_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [jval_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [jval_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  jval_pkg::cfg_t     cfg;
  jval_pkg::dp_cmd_t  cmd;
  jval_pkg::dp_sts_t  sts;
  logic               in_ready;

  assign cfg_pready  = 1'b1;
  assign in_ch.ready = in_ready;

  jval_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  jval_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jval_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_ch.vel_request),
    .in_fb     (in_ch.feedback_position),
    .in_el     (in_ch.elapsed_us),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_pos   (out_ch.command_position),
    .out_last  (out_ch.last_point)
  );

endmodule
